>>> design/v3au_pkg.sv
// Shared types and constants for the three-component vector arithmetic unit.
// Holds the command codes and the packed word types of both channels.
// No dependencies.
`timescale 1ns / 1ps

package v3au_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	typedef enum logic [3:0] {
		CMD_ADD      = 4'd0,
		CMD_SUB      = 4'd1,
		CMD_MUL      = 4'd2,
		CMD_DIV      = 4'd3,
		CMD_SCALE    = 4'd4,
		CMD_SCALEDIV = 4'd5,
		CMD_NEGATE   = 4'd6,
		CMD_DOT      = 4'd7,
		CMD_CROSS    = 4'd8,
		CMD_SQLEN    = 4'd9,
		CMD_LEN      = 4'd10,
		CMD_UNIT     = 4'd11
	} cmd_t;

	typedef struct packed {
		logic        [3:0]  command;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] scale;
	} in_t;

	typedef struct packed {
		logic signed [31:0] r_x;
		logic signed [31:0] r_y;
		logic signed [31:0] r_z;
		logic signed [31:0] r_scalar;
		logic               divide_fault;
		logic               saturated;
	} out_t;

endpackage

>>> design/vec3_arithmetic_unit.sv
// Top level of the three-component fixed-point vector arithmetic unit.
// Depends on v3au_pkg for the command codes and the channel word types.
// Uses: multipliers, a bit-per-stage square root and bit-per-stage dividers.
`timescale 1ns / 1ps

// Usage
//   Drive a command word on operands and raise start; the word is taken at a
//   rising edge with start high and busy low. busy stays low: a new word may
//   be issued on every clock.
//   Each word yields exactly one result word on result, shown for one cycle
//   with done high. The receiver cannot hold results off.
//   Operands are fixed point, Q16.16 by default. The delay from the accepting
//   edge to done is the same for every command.
//   Throughput: one word per cycle. Every word walks the whole pipe: operand
//   register, multiply, partial sum, combine/clamp, WORD_BITS square-root
//   stages, WORD_BITS + FRAC_BITS divider stages and the output register.
//   The depth is set by the restoring square root and divider, one result
//   bit per stage.
//   Reset clears all valid bits; words in flight are dropped and done stays
//   low until a new word has come through.
module vec3_arithmetic_unit #(
	parameter int WORD_BITS = v3au_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = v3au_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  v3au_pkg::in_t  operands,
	output logic           done,
	output v3au_pkg::out_t result
);

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2 * W;
	localparam int SW = PW + 2;
	localparam int Q  = W + F;

	localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [SW-1:0] HI_SW = SW'(MAXW);
	localparam logic signed [SW-1:0] LO_SW = -(SW'(MINW));
	localparam logic [Q-1:0] QPOS = Q'(MAXW);
	localparam logic [Q-1:0] QNEG = Q'(MINW);

	typedef struct packed {
		v3au_pkg::cmd_t     cmd;
		logic [2:0][W-1:0]  vres;
		logic [W-1:0]       sres;
		logic               sat;
		logic [2:0][W-1:0]  amag;
		logic [2:0]         aneg;
		logic [2:0][W-1:0]  dmag;
		logic [2:0]         dneg;
	} carry_t;

	function automatic logic signed [W-1:0] opnd(input logic [31:0] f);
		return W'(signed'(f));
	endfunction

	// {sat, value}
	function automatic logic [W:0] clamp_sw(input logic signed [SW-1:0] v);
		if (v > HI_SW)
			return {1'b1, MAXW};
		else if (v < LO_SW)
			return {1'b1, MINW};
		else
			return {1'b0, v[W-1:0]};
	endfunction

	assign busy = 1'b0;

	// ---------------- stage 1: operand register ----------------
	logic                  v_s1;
	v3au_pkg::cmd_t        cmd_s1;
	logic signed [W-1:0]   a_s1 [3];
	logic signed [W-1:0]   b_s1 [3];
	logic signed [W-1:0]   s_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		cmd_s1  <= v3au_pkg::cmd_t'(operands.command);
		a_s1[0] <= opnd(operands.a_x);
		a_s1[1] <= opnd(operands.a_y);
		a_s1[2] <= opnd(operands.a_z);
		b_s1[0] <= opnd(operands.b_x);
		b_s1[1] <= opnd(operands.b_y);
		b_s1[2] <= opnd(operands.b_z);
		s_s1    <= opnd(operands.scale);
	end

	// ---------------- stage 2: multiply ----------------
	logic signed [W-1:0]   mx [6];
	logic signed [W-1:0]   my [6];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mx[i]     = a_s1[i];
			my[i]     = b_s1[i];
			mx[i + 3] = '0;
			my[i + 3] = '0;
		end
		case (cmd_s1)
			v3au_pkg::CMD_SCALE: begin
				for (int i = 0; i < 3; i++)
					my[i] = s_s1;
			end
			v3au_pkg::CMD_SQLEN, v3au_pkg::CMD_LEN, v3au_pkg::CMD_UNIT: begin
				for (int i = 0; i < 3; i++)
					my[i] = a_s1[i];
			end
			v3au_pkg::CMD_CROSS: begin
				// x = ay*bz - az*by, y = az*bx - ax*bz, z = ax*by - ay*bx
				mx[0] = a_s1[1]; my[0] = b_s1[2];
				mx[1] = a_s1[2]; my[1] = b_s1[0];
				mx[2] = a_s1[0]; my[2] = b_s1[1];
				mx[3] = a_s1[2]; my[3] = b_s1[1];
				mx[4] = a_s1[0]; my[4] = b_s1[2];
				mx[5] = a_s1[1]; my[5] = b_s1[0];
			end
			default: begin
			end
		endcase
	end

	logic                  v_s2;
	v3au_pkg::cmd_t        cmd_s2;
	logic signed [PW-1:0]  p_s2 [6];
	logic signed [W:0]     lin_s2 [3];
	logic signed [W-1:0]   a_s2 [3];
	logic signed [W-1:0]   dsrc_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		cmd_s2 <= cmd_s1;
		for (int i = 0; i < 6; i++)
			p_s2[i] <= PW'(mx[i]) * PW'(my[i]);
		for (int i = 0; i < 3; i++) begin
			a_s2[i]    <= a_s1[i];
			dsrc_s2[i] <= (cmd_s1 == v3au_pkg::CMD_SCALEDIV) ? s_s1 : b_s1[i];
			case (cmd_s1)
				v3au_pkg::CMD_SUB:    lin_s2[i] <= (W+1)'(a_s1[i]) - (W+1)'(b_s1[i]);
				v3au_pkg::CMD_NEGATE: lin_s2[i] <= -((W+1)'(a_s1[i]));
				default:              lin_s2[i] <= (W+1)'(a_s1[i]) + (W+1)'(b_s1[i]);
			endcase
		end
	end

	// ---------------- stage 3: partial sums ----------------
	logic                   v_s3;
	v3au_pkg::cmd_t         cmd_s3;
	logic signed [PW-1:0]   p_s3 [3];
	logic signed [PW:0]     dif_s3 [3];
	logic signed [PW:0]     sum01_s3;
	logic signed [W:0]      lin_s3 [3];
	logic signed [W-1:0]    a_s3 [3];
	logic signed [W-1:0]    dsrc_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		cmd_s3   <= cmd_s2;
		sum01_s3 <= (PW+1)'(p_s2[0]) + (PW+1)'(p_s2[1]);
		for (int i = 0; i < 3; i++) begin
			p_s3[i]    <= p_s2[i];
			dif_s3[i]  <= (PW+1)'(p_s2[i]) - (PW+1)'(p_s2[i + 3]);
			lin_s3[i]  <= lin_s2[i];
			a_s3[i]    <= a_s2[i];
			dsrc_s3[i] <= dsrc_s2[i];
		end
	end

	// ---------------- stage 4: combine and clamp ----------------
	carry_t               c4;
	logic signed [SW-1:0] sum4;
	logic signed [SW-1:0] lane4 [3];
	logic [W:0]           cl4 [3];
	logic [W:0]           scl4;

	always_comb begin
		sum4     = SW'(sum01_s3) + SW'(p_s3[2]);
		c4       = '0;
		c4.cmd   = cmd_s3;
		scl4     = clamp_sw(sum4 >>> F);
		for (int i = 0; i < 3; i++) begin
			c4.amag[i] = W'(a_s3[i][W-1] ? -a_s3[i] : a_s3[i]);
			c4.aneg[i] = a_s3[i][W-1];
			c4.dmag[i] = W'(dsrc_s3[i][W-1] ? -dsrc_s3[i] : dsrc_s3[i]);
			c4.dneg[i] = dsrc_s3[i][W-1];
			case (cmd_s3)
				v3au_pkg::CMD_MUL, v3au_pkg::CMD_SCALE: lane4[i] = SW'(p_s3[i] >>> F);
				v3au_pkg::CMD_CROSS:                    lane4[i] = SW'(dif_s3[i] >>> F);
				default:                                lane4[i] = SW'(lin_s3[i]);
			endcase
			cl4[i] = clamp_sw(lane4[i]);
		end
		case (cmd_s3)
			v3au_pkg::CMD_ADD, v3au_pkg::CMD_SUB, v3au_pkg::CMD_MUL, v3au_pkg::CMD_SCALE,
			v3au_pkg::CMD_NEGATE, v3au_pkg::CMD_CROSS: begin
				for (int i = 0; i < 3; i++)
					c4.vres[i] = cl4[i][W-1:0];
				c4.sat = cl4[0][W] | cl4[1][W] | cl4[2][W];
			end
			v3au_pkg::CMD_DOT, v3au_pkg::CMD_SQLEN: begin
				c4.sres = scl4[W-1:0];
				c4.sat  = scl4[W];
			end
			default: begin
			end
		endcase
	end

	logic             v_s4;
	carry_t           c_s4;
	logic [PW-1:0]    sq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		c_s4  <= c4;
		sq_s4 <= sum4[PW-1:0];
	end

	// ---------------- square root: one root bit per stage ----------------
	logic             sqrt_v_sn    [1:W];
	carry_t           sqrt_c_sn    [1:W];
	logic [PW-1:0]    sqrt_rem_sn  [1:W];
	logic [W-1:0]     sqrt_root_sn [1:W];

	for (genvar k = 1; k <= W; k++) begin : g_sqrt
		localparam int B = W - k;
		logic          pv;
		carry_t        pc;
		logic [PW-1:0] prem;
		logic [W-1:0]  proot;
		logic [PW-1:0] trial;

		if (k == 1) begin : g_first
			assign pv    = v_s4;
			assign pc    = c_s4;
			assign prem  = sq_s4;
			assign proot = '0;
		end else begin : g_next
			assign pv    = sqrt_v_sn[k-1];
			assign pc    = sqrt_c_sn[k-1];
			assign prem  = sqrt_rem_sn[k-1];
			assign proot = sqrt_root_sn[k-1];
		end

		// (r + 2^B)^2 - r^2
		assign trial = (PW'(proot) << (B + 1)) + (PW'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sqrt_v_sn[k] <= 1'b0;
			else
				sqrt_v_sn[k] <= pv;
		end

		always_ff @(posedge clk) begin
			sqrt_c_sn[k] <= pc;
			if (prem >= trial) begin
				sqrt_rem_sn[k]  <= prem - trial;
				sqrt_root_sn[k] <= proot | (W'(1) << B);
			end else begin
				sqrt_rem_sn[k]  <= prem;
				sqrt_root_sn[k] <= proot;
			end
		end
	end

	// ---------------- divider entry: pick divisor, finish length ----------------
	carry_t        c_d0;
	logic [W-1:0]  root_d0;

	always_comb begin
		root_d0 = sqrt_root_sn[W];
		c_d0    = sqrt_c_sn[W];
		case (c_d0.cmd)
			v3au_pkg::CMD_UNIT: begin
				for (int i = 0; i < 3; i++) begin
					c_d0.dmag[i] = root_d0;
					c_d0.dneg[i] = 1'b0;
				end
			end
			v3au_pkg::CMD_LEN: begin
				c_d0.sres = (root_d0 > MAXW) ? MAXW : root_d0;
				c_d0.sat  = (root_d0 > MAXW);
			end
			default: begin
			end
		endcase
	end

	// ---------------- divider: one quotient bit per stage, three lanes ----------------
	logic                 div_v_sn   [1:Q];
	carry_t               div_c_sn   [1:Q];
	logic [2:0][W-1:0]    div_rem_sn [1:Q];
	logic [2:0][Q-1:0]    div_nq_sn  [1:Q];

	for (genvar j = 1; j <= Q; j++) begin : g_div
		logic              pv;
		carry_t            pc;
		logic [2:0][W-1:0] prem;
		logic [2:0][Q-1:0] pnq;
		logic [2:0][W-1:0] nrem;
		logic [2:0][Q-1:0] nnq;
		logic [W:0]        shifted [3];

		if (j == 1) begin : g_first
			assign pv = sqrt_v_sn[W];
			assign pc = c_d0;
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					prem[i] = '0;
					pnq[i]  = Q'(c_d0.amag[i]) << F;
				end
			end
		end else begin : g_next
			assign pv   = div_v_sn[j-1];
			assign pc   = div_c_sn[j-1];
			assign prem = div_rem_sn[j-1];
			assign pnq  = div_nq_sn[j-1];
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				shifted[i] = {prem[i], pnq[i][Q-1]};
				if (shifted[i] >= {1'b0, pc.dmag[i]}) begin
					nrem[i] = W'(shifted[i] - {1'b0, pc.dmag[i]});
					nnq[i]  = {pnq[i][Q-2:0], 1'b1};
				end else begin
					nrem[i] = shifted[i][W-1:0];
					nnq[i]  = {pnq[i][Q-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				div_v_sn[j] <= 1'b0;
			else
				div_v_sn[j] <= pv;
		end

		always_ff @(posedge clk) begin
			div_c_sn[j]   <= pc;
			div_rem_sn[j] <= nrem;
			div_nq_sn[j]  <= nnq;
		end
	end

	// ---------------- output: sign and clamp the quotients ----------------
	carry_t            cq;
	logic [2:0][Q-1:0] quo;
	logic [W-1:0]      rv [3];
	logic              fault_o;
	logic              sat_o;
	logic              is_div;
	logic              qneg;

	always_comb begin
		cq      = div_c_sn[Q];
		quo     = div_nq_sn[Q];
		fault_o = 1'b0;
		sat_o   = cq.sat;
		is_div  = (cq.cmd == v3au_pkg::CMD_DIV) || (cq.cmd == v3au_pkg::CMD_SCALEDIV) ||
		          (cq.cmd == v3au_pkg::CMD_UNIT);
		qneg    = 1'b0;
		for (int i = 0; i < 3; i++) begin
			rv[i] = cq.vres[i];
			if (is_div) begin
				qneg = cq.aneg[i] ^ cq.dneg[i];
				if (cq.dmag[i] == '0) begin
					// zero divisor: zero stays zero, else rail by dividend sign
					fault_o = 1'b1;
					if (cq.amag[i] == '0) begin
						rv[i] = '0;
					end else begin
						sat_o = 1'b1;
						rv[i] = cq.aneg[i] ? MINW : MAXW;
					end
				end else if (!qneg) begin
					if (quo[i] > QPOS) begin
						sat_o = 1'b1;
						rv[i] = MAXW;
					end else begin
						rv[i] = quo[i][W-1:0];
					end
				end else begin
					if (quo[i] > QNEG) begin
						sat_o = 1'b1;
						rv[i] = MINW;
					end else begin
						rv[i] = -quo[i][W-1:0];
					end
				end
			end
		end
	end

	logic            done_q;
	v3au_pkg::out_t  res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= div_v_sn[Q];
	end

	always_ff @(posedge clk) begin
		res_q.r_x          <= 32'(signed'(rv[0]));
		res_q.r_y          <= 32'(signed'(rv[1]));
		res_q.r_z          <= 32'(signed'(rv[2]));
		res_q.r_scalar     <= 32'(signed'(cq.sres));
		res_q.divide_fault <= fault_o;
		res_q.saturated    <= sat_o;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
